@@ rtl/phong_vertex_lighting_defines.svh @@
// ----------------------------------------------------------------------------
// Phong vertex lighting assertion macros
// Shared concurrent assertion forms clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PHONG_VERTEX_LIGHTING_DEFINES_SVH
`define PHONG_VERTEX_LIGHTING_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define PVL_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define PVL_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PVL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pvl_pkg.sv @@
// ----------------------------------------------------------------------------
// Phong vertex lighting package
// Shared constants, register codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package pvl_pkg;

	localparam int COORD_WIDTH_DEF   = 16;
	localparam int EXPONENT_BITS_DEF = 8;

	localparam int CFG_W  = 48;
	localparam int IDX_W  = 3;
	localparam int COMP_W = 16;
	localparam int FRAC_W = 14;
	localparam int UNIT_W = 15;

	localparam logic [UNIT_W-1:0] UNIT_ONE = 15'd16384;

	localparam int NORM_LAT = 53;

	typedef enum logic [IDX_W-1:0] {
		REG_AMB_LEVEL  = 3'd0,
		REG_AMB_COEFS  = 3'd1,
		REG_DIF_COEFS  = 3'd2,
		REG_SPC_COEFS  = 3'd3,
		REG_LIGHT_POS  = 3'd4,
		REG_LIGHT_COL  = 3'd5,
		REG_SHININESS  = 3'd6
	} cfg_reg_t;

	localparam logic [15:0]      RST_AMB_LEVEL = 16'd13107;
	localparam logic [CFG_W-1:0] RST_AMB_COEFS = 48'd2147483648;
	localparam logic [CFG_W-1:0] RST_DIF_COEFS = 48'd1073741824;
	localparam logic [CFG_W-1:0] RST_SPC_COEFS = 48'd70369817935872;
	localparam logic [CFG_W-1:0] RST_LIGHT_POS = 48'd228699492368384;
	localparam logic [CFG_W-1:0] RST_LIGHT_COL = 48'd140739635871744;
	localparam logic [7:0]       RST_SHININESS = 8'd32;

endpackage

`default_nettype wire

@@ rtl/pvl_norm.sv @@
// ----------------------------------------------------------------------------
// Vector normalizer
// Scales a signed 3-vector to unit length in Q1.14 through a pipelined
// magnitude, shift, square root and division datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "phong_vertex_lighting_defines.svh"

module pvl_norm #(
	parameter int IN_W = 17,
	parameter int SB_W = 1
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire logic                                 in_vld,
	input  wire logic [2:0][IN_W-1:0]                 in_vec,
	input  wire logic [SB_W-1:0]                      in_sb,
	output logic                                      out_vld,
	output logic [2:0][pvl_pkg::COMP_W-1:0]           out_vec,
	output logic                                      out_zero,
	output logic [SB_W-1:0]                           out_sb
);

	localparam int KW    = $clog2(IN_W);
	localparam int XW    = (IN_W > 30) ? IN_W : 30;
	localparam int SQ_N  = 32;
	localparam int DIV_N = pvl_pkg::UNIT_W;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0][IN_W-1:0] mag_s1, mag_s2;
	logic [2:0]           neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [SB_W-1:0]      sb_s1, sb_s2, sb_s3, sb_s4, sb_s5;
	logic [KW-1:0]        k_s2;
	logic                 z_s2, z_s3, z_s4, z_s5;
	logic [2:0][29:0]     sh_s3, sh_s4, sh_s5;
	logic [2:0][59:0]     sq_s4;
	logic [61:0]          sum_s5;

	logic [IN_W-1:0]      or_m;
	logic [KW-1:0]        k_c;
	logic [2:0][XW-1:0]   x_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		or_m = mag_s1[0] | mag_s1[1] | mag_s1[2];
		k_c  = '0;
		for (int j = 0; j < IN_W; j++) begin
			if (or_m[j]) begin
				k_c = KW'(j);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			x_c[i] = XW'(mag_s2[i]);
			if (int'(k_s2) > 29) begin
				x_c[i] = x_c[i] >> (int'(k_s2) - 29);
			end else if (int'(k_s2) < 28) begin
				x_c[i] = x_c[i] << (28 - int'(k_s2));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= in_vec[i][IN_W-1];
				mag_s1[i] <= in_vec[i][IN_W-1] ? IN_W'(-$signed(in_vec[i])) : in_vec[i];
				sh_s3[i]  <= x_c[i][29:0];
				sq_s4[i]  <= 60'(sh_s3[i]) * 60'(sh_s3[i]);
			end
			sb_s1  <= in_sb;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			sb_s2  <= sb_s1;
			k_s2   <= k_c;
			z_s2   <= (or_m == '0);
			neg_s3 <= neg_s2;
			sb_s3  <= sb_s2;
			z_s3   <= z_s2;
			sh_s4  <= sh_s3;
			neg_s4 <= neg_s3;
			sb_s4  <= sb_s3;
			z_s4   <= z_s3;
			sum_s5 <= 62'(sq_s4[0]) + 62'(sq_s4[1]) + 62'(sq_s4[2]);
			sh_s5  <= sh_s4;
			neg_s5 <= neg_s4;
			sb_s5  <= sb_s4;
			z_s5   <= z_s4;
		end
	end

	logic [61:0]      rx_s  [1:SQ_N];
	logic [62:0]      rr_s  [1:SQ_N];
	logic [2:0][29:0] rm_s  [1:SQ_N];
	logic [2:0]       rn_s  [1:SQ_N];
	logic             rz_s  [1:SQ_N];
	logic [SB_W-1:0]  rsb_s [1:SQ_N];
	logic             rv_s  [1:SQ_N];

	for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
		localparam logic [62:0] BIT = 63'(1) << (62 - 2 * j);
		logic [61:0]      x_i;
		logic [62:0]      r_i;
		logic [2:0][29:0] m_i;
		logic [2:0]       n_i;
		logic             z_i;
		logic [SB_W-1:0]  sb_i;
		logic             v_i;
		logic [62:0]      t_i;
		logic             ge_i;

		if (j == 0) begin : g_first
			assign x_i  = sum_s5;
			assign r_i  = '0;
			assign m_i  = sh_s5;
			assign n_i  = neg_s5;
			assign z_i  = z_s5;
			assign sb_i = sb_s5;
			assign v_i  = v_s5;
		end else begin : g_rest
			assign x_i  = rx_s[j];
			assign r_i  = rr_s[j];
			assign m_i  = rm_s[j];
			assign n_i  = rn_s[j];
			assign z_i  = rz_s[j];
			assign sb_i = rsb_s[j];
			assign v_i  = rv_s[j];
		end

		assign t_i  = r_i + BIT;
		assign ge_i = ({1'b0, x_i} >= t_i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s[j+1] <= 1'b0;
			end else if (en) begin
				rv_s[j+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[j+1]  <= ge_i ? (x_i - t_i[61:0]) : x_i;
				rr_s[j+1]  <= ge_i ? ((r_i >> 1) + BIT) : (r_i >> 1);
				rm_s[j+1]  <= m_i;
				rn_s[j+1]  <= n_i;
				rz_s[j+1]  <= z_i;
				rsb_s[j+1] <= sb_i;
			end
		end
	end

	logic [2:0][31:0]        dr_s  [1:DIV_N];
	logic [2:0][DIV_N-1:0]   dq_s  [1:DIV_N];
	logic [30:0]             dl_s  [1:DIV_N];
	logic [2:0]              dn_s  [1:DIV_N];
	logic                    dz_s  [1:DIV_N];
	logic [SB_W-1:0]         dsb_s [1:DIV_N];
	logic                    dv_s  [1:DIV_N];

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		logic [2:0][31:0]      r_i;
		logic [2:0][DIV_N-1:0] q_i;
		logic [30:0]           l_i;
		logic [2:0]            n_i;
		logic                  z_i;
		logic [SB_W-1:0]       sb_i;
		logic                  v_i;
		logic [2:0]            ge_i;
		logic [2:0][31:0]      rn_i;

		if (k == 0) begin : g_first
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign r_i[i] = 32'(rm_s[SQ_N][i]);
			end
			assign q_i  = '0;
			assign l_i  = rr_s[SQ_N][30:0];
			assign n_i  = rn_s[SQ_N];
			assign z_i  = rz_s[SQ_N];
			assign sb_i = rsb_s[SQ_N];
			assign v_i  = rv_s[SQ_N];
		end else begin : g_rest
			assign r_i  = dr_s[k];
			assign q_i  = dq_s[k];
			assign l_i  = dl_s[k];
			assign n_i  = dn_s[k];
			assign z_i  = dz_s[k];
			assign sb_i = dsb_s[k];
			assign v_i  = dv_s[k];
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				ge_i[i] = (r_i[i] >= 32'(l_i));
				rn_i[i] = ge_i[i] ? (r_i[i] - 32'(l_i)) : r_i[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_s[k+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dr_s[k+1][i] <= rn_i[i] << 1;
					dq_s[k+1][i] <= {q_i[i][DIV_N-2:0], ge_i[i]};
				end
				dl_s[k+1]  <= l_i;
				dn_s[k+1]  <= n_i;
				dz_s[k+1]  <= z_i;
				dsb_s[k+1] <= sb_i;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= dv_s[DIV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dz_s[DIV_N]) begin
					out_vec[i] <= '0;
				end else if (dn_s[DIV_N][i]) begin
					out_vec[i] <= -{1'b0, dq_s[DIV_N][i]};
				end else begin
					out_vec[i] <= {1'b0, dq_s[DIV_N][i]};
				end
			end
			out_zero <= dz_s[DIV_N];
			out_sb   <= dsb_s[DIV_N];
		end
	end

	`PVL_ASSERT_IMPLIES(a_unit_range, out_vld,
		($signed(out_vec[0]) <= 16'sd16384) && ($signed(out_vec[0]) >= -16'sd16384) &&
		($signed(out_vec[1]) <= 16'sd16384) && ($signed(out_vec[1]) >= -16'sd16384) &&
		($signed(out_vec[2]) <= 16'sd16384) && ($signed(out_vec[2]) >= -16'sd16384),
		"unit vector component out of range")

endmodule

`default_nettype wire

@@ rtl/pvl_pow.sv @@
// ----------------------------------------------------------------------------
// Specular power unit
// Raises a Q.14 base to an integer exponent by pipelined square and multiply,
// one exponent bit per stage from the least significant bit.
// ----------------------------------------------------------------------------
`default_nettype none

module pvl_pow #(
	parameter int EXP_W = 8,
	parameter int SB_W  = 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_vld,
	input  wire logic [pvl_pkg::UNIT_W-1:0]   in_base,
	input  wire logic [EXP_W-1:0]             exp_bits,
	input  wire logic [SB_W-1:0]              in_sb,
	output logic                              out_vld,
	output logic [pvl_pkg::UNIT_W-1:0]        out_spec,
	output logic [SB_W-1:0]                   out_sb
);

	localparam int UW = pvl_pkg::UNIT_W;
	localparam int FW = pvl_pkg::FRAC_W;

	logic          pv_s   [1:EXP_W];
	logic [UW-1:0] spec_s [1:EXP_W];
	logic [UW-1:0] base_s [1:EXP_W];
	logic [SB_W-1:0] sb_s [1:EXP_W];

	for (genvar i = 0; i < EXP_W; i++) begin : g_step
		logic            v_i;
		logic [UW-1:0]   spec_i;
		logic [UW-1:0]   base_i;
		logic [SB_W-1:0] sb_i;
		logic [2*UW-1:0] sp_i;
		logic [2*UW-1:0] bp_i;

		if (i == 0) begin : g_first
			assign v_i    = in_vld;
			assign spec_i = pvl_pkg::UNIT_ONE;
			assign base_i = in_base;
			assign sb_i   = in_sb;
		end else begin : g_rest
			assign v_i    = pv_s[i];
			assign spec_i = spec_s[i];
			assign base_i = base_s[i];
			assign sb_i   = sb_s[i];
		end

		assign sp_i = (2*UW)'(spec_i) * (2*UW)'(base_i);
		assign bp_i = (2*UW)'(base_i) * (2*UW)'(base_i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pv_s[i+1] <= 1'b0;
			end else if (en) begin
				pv_s[i+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				spec_s[i+1] <= exp_bits[i] ? sp_i[FW+UW-1:FW] : spec_i;
				base_s[i+1] <= bp_i[FW+UW-1:FW];
				sb_s[i+1]   <= sb_i;
			end
		end
	end

	assign out_vld  = pv_s[EXP_W];
	assign out_spec = spec_s[EXP_W];
	assign out_sb   = sb_s[EXP_W];

endmodule

`default_nettype wire

@@ rtl/phong_vertex_lighting.sv @@
// Throughput: one vertex per cycle while vertex_stall is low; each vector normalizer is a 53-stage pipeline.
// An output register with one skid entry holds results while the color side stalls.
// Reset clears all valid bits and loads the default lighting registers.
// ----------------------------------------------------------------------------
// Phong vertex lighting
// Single point light Phong shading of one vertex per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "phong_vertex_lighting_defines.svh"

module phong_vertex_lighting #(
	parameter int COORD_WIDTH   = pvl_pkg::COORD_WIDTH_DEF,
	parameter int EXPONENT_BITS = pvl_pkg::EXPONENT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [pvl_pkg::IDX_W-1:0]         cfg_index,
	input  wire logic [pvl_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                              vertex_valid,
	output logic                                   vertex_stall,
	input  wire logic signed [COORD_WIDTH-1:0]     pos_x,
	input  wire logic signed [COORD_WIDTH-1:0]     pos_y,
	input  wire logic signed [COORD_WIDTH-1:0]     pos_z,
	input  wire logic signed [15:0]                norm_x,
	input  wire logic signed [15:0]                norm_y,
	input  wire logic signed [15:0]                norm_z,
	output logic                                   color_valid,
	input  wire logic                              color_stall,
	output logic [15:0]                            red,
	output logic [15:0]                            green,
	output logic [15:0]                            blue,
	output logic                                   degenerate
);

	localparam int CW  = COORD_WIDTH;
	localparam int LW  = ((CW > 16) ? CW : 16) + 1;
	localparam int VW  = CW + 1;
	localparam int RW  = 35;
	localparam int PW  = (EXPONENT_BITS > 8) ? EXPONENT_BITS : 8;
	localparam int RSB = 48 + 18 + 2;
	localparam int PSB = 18 + 3;

	logic [15:0]                 amb_level_q;
	logic [pvl_pkg::CFG_W-1:0]   amb_coef_q, dif_coef_q, spc_coef_q, light_pos_q, light_col_q;
	logic [7:0]                  shin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amb_level_q <= pvl_pkg::RST_AMB_LEVEL;
			amb_coef_q  <= pvl_pkg::RST_AMB_COEFS;
			dif_coef_q  <= pvl_pkg::RST_DIF_COEFS;
			spc_coef_q  <= pvl_pkg::RST_SPC_COEFS;
			light_pos_q <= pvl_pkg::RST_LIGHT_POS;
			light_col_q <= pvl_pkg::RST_LIGHT_COL;
			shin_q      <= pvl_pkg::RST_SHININESS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pvl_pkg::REG_AMB_LEVEL: amb_level_q <= cfg_data[15:0];
				pvl_pkg::REG_AMB_COEFS: amb_coef_q  <= cfg_data;
				pvl_pkg::REG_DIF_COEFS: dif_coef_q  <= cfg_data;
				pvl_pkg::REG_SPC_COEFS: spc_coef_q  <= cfg_data;
				pvl_pkg::REG_LIGHT_POS: light_pos_q <= cfg_data;
				pvl_pkg::REG_LIGHT_COL: light_col_q <= cfg_data;
				pvl_pkg::REG_SHININESS: shin_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	logic skid_full_q, out_vld_q;
	logic en;
	logic in_fire;
	logic [2:0][CW-1:0] pos_vec;

	assign en           = !skid_full_q;
	assign vertex_stall = skid_full_q;
	assign in_fire      = vertex_valid && !vertex_stall;
	assign pos_vec      = {pos_z, pos_y, pos_x};

	logic               v_s1;
	logic [2:0][LW-1:0] lv_s1;
	logic [2:0][VW-1:0] vv_s1;
	logic [2:0][15:0]   n_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				lv_s1[i] <= LW'($signed(light_pos_q[16*i +: 16])) - LW'($signed(pos_vec[i]));
				vv_s1[i] <= -VW'($signed(pos_vec[i]));
			end
			n_s1 <= {norm_z, norm_y, norm_x};
		end
	end

	logic             l_vld, v_vld, lz, vz;
	logic [2:0][15:0] lu, vu;
	logic [31:0]      lsb;
	logic [15:0]      vsb;
	logic [2:0][15:0] n_o;

	pvl_norm #(.IN_W(LW), .SB_W(32)) u_norm_l (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(v_s1), .in_vec(lv_s1), .in_sb({n_s1[1], n_s1[0]}),
		.out_vld(l_vld), .out_vec(lu), .out_zero(lz), .out_sb(lsb)
	);

	pvl_norm #(.IN_W(VW), .SB_W(16)) u_norm_v (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(v_s1), .in_vec(vv_s1), .in_sb(n_s1[2]),
		.out_vld(v_vld), .out_vec(vu), .out_zero(vz), .out_sb(vsb)
	);

	assign n_o = {vsb, lsb};

	logic               v_s2, v_s3, v_s4, v_s5;
	logic [2:0][31:0]   np_s2;
	logic [2:0][15:0]   l_s2, l_s3, l_s4;
	logic [2:0][15:0]   vu_s2, vu_s3, vu_s4, vu_s5;
	logic [2:0][15:0]   n_s2, n_s3;
	logic               dg_s2, dg_s3, dg_s4, dg_s5;
	logic [17:0]        nl14_s3, nl14_s4, nl14_s5;
	logic               nlpos_s3, nlpos_s4, nlpos_s5;
	logic [2:0][33:0]   rp_s4;
	logic [2:0][RW-1:0] rvec_s5;
	logic signed [31:0] nl28_c;

	assign nl28_c = $signed(np_s2[0]) + $signed(np_s2[1]) + $signed(np_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s2 <= l_vld;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				np_s2[i]   <= 32'($signed(n_o[i])) * 32'($signed(lu[i]));
				rp_s4[i]   <= 34'($signed(nl14_s3)) * 34'($signed(n_s3[i]));
				rvec_s5[i] <= (RW'($signed(rp_s4[i])) <<< 1) - (RW'($signed(l_s4[i])) <<< 14);
			end
			l_s2     <= lu;
			vu_s2    <= vu;
			n_s2     <= n_o;
			dg_s2    <= lz || vz;
			nl14_s3  <= nl28_c[31:14];
			nlpos_s3 <= !nl28_c[31] && (nl28_c != 32'sd0);
			l_s3     <= l_s2;
			vu_s3    <= vu_s2;
			n_s3     <= n_s2;
			dg_s3    <= dg_s2;
			l_s4     <= l_s3;
			vu_s4    <= vu_s3;
			nl14_s4  <= nl14_s3;
			nlpos_s4 <= nlpos_s3;
			dg_s4    <= dg_s3;
			vu_s5    <= vu_s4;
			nl14_s5  <= nl14_s4;
			nlpos_s5 <= nlpos_s4;
			dg_s5    <= dg_s4;
		end
	end

	logic             r_vld, rz;
	logic [2:0][15:0] ru;
	logic [RSB-1:0]   rsb;
	logic [2:0][15:0] v_o;

	pvl_norm #(.IN_W(RW), .SB_W(RSB)) u_norm_r (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(v_s5), .in_vec(rvec_s5), .in_sb({vu_s5, nl14_s5, nlpos_s5, dg_s5}),
		.out_vld(r_vld), .out_vec(ru), .out_zero(rz), .out_sb(rsb)
	);

	assign v_o = rsb[RSB-1:20];

	logic                       v_s6, v_s7;
	logic [2:0][31:0]           rvp_s6;
	logic [17:0]                nl14_s6, nl14_s7;
	logic                       nlpos_s6, nlpos_s7, dg_s6, dg_s7, rvpos_s7;
	logic [pvl_pkg::UNIT_W-1:0] base_s7;
	logic signed [31:0]         rv28_c;
	logic [17:0]                r14_c;

	assign rv28_c = $signed(rvp_s6[0]) + $signed(rvp_s6[1]) + $signed(rvp_s6[2]);
	assign r14_c  = rv28_c[31:14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= r_vld;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rvp_s6[i] <= 32'($signed(ru[i])) * 32'($signed(v_o[i]));
			end
			nl14_s6  <= rsb[19:2];
			nlpos_s6 <= rsb[1];
			dg_s6    <= rsb[0] || rz;
			nl14_s7  <= nl14_s6;
			nlpos_s7 <= nlpos_s6;
			dg_s7    <= dg_s6;
			rvpos_s7 <= !rv28_c[31] && (rv28_c != 32'sd0);
			if (rv28_c[31] || (rv28_c == 32'sd0)) begin
				base_s7 <= '0;
			end else if ($signed(r14_c) > 18'sd16384) begin
				base_s7 <= pvl_pkg::UNIT_ONE;
			end else begin
				base_s7 <= r14_c[pvl_pkg::UNIT_W-1:0];
			end
		end
	end

	logic                       p_vld;
	logic [pvl_pkg::UNIT_W-1:0] spec_o;
	logic [PSB-1:0]             psb;
	logic [PW-1:0]              shin_w;

	assign shin_w = PW'(shin_q);

	pvl_pow #(.EXP_W(EXPONENT_BITS), .SB_W(PSB)) u_pow (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(v_s7), .in_base(base_s7), .exp_bits(shin_w[EXPONENT_BITS-1:0]),
		.in_sb({nl14_s7, nlpos_s7, rvpos_s7, dg_s7}),
		.out_vld(p_vld), .out_spec(spec_o), .out_sb(psb)
	);

	logic                       v_s8, v_s9, v_s10;
	logic [2:0][31:0]           amb_s8, amb_s9, ld_s8, ls_s8;
	logic [2:0][48:0]           d_s9;
	logic [2:0][46:0]           s_s9;
	logic [16:0]                nlu_s8;
	logic [pvl_pkg::UNIT_W-1:0] spec_s8;
	logic                       nlpos_s8, nlpos_s9, rvpos_s8, rvpos_s9;
	logic                       dg_s8, dg_s9, dg_s10;
	logic [2:0][15:0]           col_s10;
	logic [2:0][19:0]           sum_c;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_c[c] = 20'(amb_s9[c][31:17])
				+ (nlpos_s9 ? 20'(d_s9[c][48:30]) : 20'd0)
				+ (rvpos_s9 ? 20'(s_s9[c][46:30]) : 20'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s8  <= p_vld;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				amb_s8[c]  <= 32'(amb_level_q) * 32'(amb_coef_q[16*c +: 16]);
				ld_s8[c]   <= 32'(light_col_q[16*c +: 16]) * 32'(dif_coef_q[16*c +: 16]);
				ls_s8[c]   <= 32'(light_col_q[16*c +: 16]) * 32'(spc_coef_q[16*c +: 16]);
				d_s9[c]    <= 49'(ld_s8[c]) * 49'(nlu_s8);
				s_s9[c]    <= 47'(ls_s8[c]) * 47'(spec_s8);
				col_s10[c] <= (sum_c[c] > 20'd65535) ? 16'hFFFF : sum_c[c][15:0];
			end
			nlu_s8   <= psb[19:3];
			nlpos_s8 <= psb[2];
			rvpos_s8 <= psb[1];
			dg_s8    <= psb[0];
			spec_s8  <= spec_o;
			amb_s9   <= amb_s8;
			nlpos_s9 <= nlpos_s8;
			rvpos_s9 <= rvpos_s8;
			dg_s9    <= dg_s8;
			dg_s10   <= dg_s9;
		end
	end

	logic             pipe_fire;
	logic             take;
	logic [2:0][15:0] out_col_q, skid_col_q;
	logic             out_dg_q, skid_dg_q;

	assign pipe_fire = v_s10 && en;
	assign take      = !out_vld_q || !color_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (take) begin
			out_vld_q   <= skid_full_q || pipe_fire;
			skid_full_q <= 1'b0;
		end else if (pipe_fire) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_col_q <= skid_full_q ? skid_col_q : col_s10;
			out_dg_q  <= skid_full_q ? skid_dg_q : dg_s10;
		end else if (pipe_fire) begin
			skid_col_q <= col_s10;
			skid_dg_q  <= dg_s10;
		end
	end

	assign color_valid = out_vld_q;
	assign red         = out_col_q[0];
	assign green       = out_col_q[1];
	assign blue        = out_col_q[2];
	assign degenerate  = out_dg_q;

	`PVL_ASSERT_HOLDS(a_norm_lockstep, l_vld == v_vld,
		"light and view normalizers out of step")
	`PVL_ASSERT_IMPLIES(a_skid_behind_out, skid_full_q, out_vld_q,
		"skid entry held without an output word")
	`PVL_ASSERT_NEXT(a_skid_catch, out_vld_q && color_stall && pipe_fire, skid_full_q,
		"result word leaving the pipeline was dropped")

endmodule

`default_nettype wire

@@ test/phong_vertex_lighting_tb.sv @@
// ----------------------------------------------------------------------------
// Phong vertex lighting testbench
// Streams vertex words through the lighting unit under several register
// settings. A bit-exact shading predictor computes the color word of every
// accepted vertex, and the color side is checked in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phong_vertex_lighting_tb;

	localparam int LIMIT = 600000;

	typedef longint vec3_t [3];

	typedef struct {
		logic signed [15:0] px, py, pz, nx, ny, nz;
	} vertex_t;

	typedef struct {
		logic [15:0] r, g, b;
		logic        dg;
	} color_t;

	logic                      clk = 0;
	logic                      arst_n = 0;
	logic                      cfg_we = 0;
	pvl_pkg::cfg_reg_t         cfg_index = pvl_pkg::REG_AMB_LEVEL;
	logic [pvl_pkg::CFG_W-1:0] cfg_data = '0;
	logic                      vertex_valid = 0;
	logic                      vertex_stall;
	logic signed [15:0]        pos_x = 0, pos_y = 0, pos_z = 0;
	logic signed [15:0]        norm_x = 0, norm_y = 0, norm_z = 0;
	logic                      color_valid;
	logic                      color_stall = 0;
	logic [15:0]               red, green, blue;
	logic                      degenerate;

	phong_vertex_lighting dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.vertex_valid(vertex_valid), .vertex_stall(vertex_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.color_valid(color_valid), .color_stall(color_stall),
		.red(red), .green(green), .blue(blue), .degenerate(degenerate)
	);

	// Shadow copy of the lighting registers.
	logic [15:0]               amb_level;
	logic [pvl_pkg::CFG_W-1:0] amb_k, dif_k, spc_k, light_pos, light_col;
	logic [7:0]                shine;

	vertex_t pending_vertices[$];
	color_t  expected_colors[$];
	int      mismatches = 0;
	int      colors_seen = 0;
	int      vertices_sent = 0;
	int      cycles = 0;
	int      burst_left = 0;
	int      gap_left = 0;
	int      stall_mode = 0;
	int      stall_span = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Returns 1 when the vector is all zero.
	function automatic bit unit_vec(input vec3_t v, output vec3_t u);
		longint unsigned mag[3];
		longint unsigned m, sum, len;
		bit neg[3];
		m = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = v[i] < 0;
			mag[i] = neg[i] ? -v[i] : v[i];
			if (mag[i] > m)
				m = mag[i];
		end
		if (m == 0) begin
			u = '{0, 0, 0};
			return 1;
		end
		while (m >= (64'd1 << 30)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++)
				mag[i] >>= 1;
		end
		while (m < (64'd1 << 28)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++)
				mag[i] <<= 1;
		end
		for (int i = 0; i < 3; i++)
			sum += mag[i] * mag[i];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			u[i] = longint'((mag[i] << 14) / len);
			if (neg[i])
				u[i] = -u[i];
		end
		return 0;
	endfunction

	function automatic color_t shade_vertex(input vertex_t vx);
		vec3_t pos, nrm, lv, vv, rvec, lu, vu, ru;
		longint nl28, nl14, rv28, r14;
		longint unsigned spec, base, p, lc, sum;
		bit dg;
		logic [15:0] ch[3];
		color_t c;
		pos = '{vx.px, vx.py, vx.pz};
		nrm = '{vx.nx, vx.ny, vx.nz};
		for (int i = 0; i < 3; i++) begin
			lv[i] = longint'($signed(light_pos[16*i +: 16])) - pos[i];
			vv[i] = -pos[i];
		end
		dg = unit_vec(lv, lu);
		dg = unit_vec(vv, vu) | dg;
		nl28 = 0;
		for (int i = 0; i < 3; i++)
			nl28 += nrm[i] * lu[i];
		nl14 = nl28 >>> 14;
		for (int i = 0; i < 3; i++)
			rvec[i] = 2 * nl14 * nrm[i] - lu[i] * 16384;
		dg = unit_vec(rvec, ru) | dg;
		rv28 = 0;
		for (int i = 0; i < 3; i++)
			rv28 += ru[i] * vu[i];
		spec = 0;
		if (rv28 > 0) begin
			r14 = rv28 >>> 14;
			if (r14 > 16384)
				r14 = 16384;
			base = r14;
			spec = 16384;
			p = 64'(shine);
			while (p != 0) begin
				if (p[0])
					spec = (spec * base) >> 14;
				base = (base * base) >> 14;
				p >>= 1;
			end
		end
		for (int i = 0; i < 3; i++) begin
			lc = 64'(light_col[16*i +: 16]);
			sum = (longint'(amb_level) * amb_k[16*i +: 16]) >> 17;
			if (nl28 > 0)
				sum += (lc * dif_k[16*i +: 16] * longint'(nl14)) >> 30;
			if (rv28 > 0)
				sum += (lc * spc_k[16*i +: 16] * spec) >> 30;
			ch[i] = sum > 65535 ? 16'hFFFF : sum[15:0];
		end
		c.r = ch[0];
		c.g = ch[1];
		c.b = ch[2];
		c.dg = dg;
		return c;
	endfunction

	task automatic write_reg(input pvl_pkg::cfg_reg_t idx,
			input logic [pvl_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			pvl_pkg::REG_AMB_LEVEL: amb_level = val[15:0];
			pvl_pkg::REG_AMB_COEFS: amb_k = val;
			pvl_pkg::REG_DIF_COEFS: dif_k = val;
			pvl_pkg::REG_SPC_COEFS: spc_k = val;
			pvl_pkg::REG_LIGHT_POS: light_pos = val;
			pvl_pkg::REG_LIGHT_COL: light_col = val;
			pvl_pkg::REG_SHININESS: shine = val[7:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [15:0] al, input logic [pvl_pkg::CFG_W-1:0] ak,
			input logic [pvl_pkg::CFG_W-1:0] dk, input logic [pvl_pkg::CFG_W-1:0] sk,
			input logic [pvl_pkg::CFG_W-1:0] lp, input logic [pvl_pkg::CFG_W-1:0] lc,
			input logic [7:0] sh);
		write_reg(pvl_pkg::REG_AMB_LEVEL, {32'd0, al});
		write_reg(pvl_pkg::REG_AMB_COEFS, ak);
		write_reg(pvl_pkg::REG_DIF_COEFS, dk);
		write_reg(pvl_pkg::REG_SPC_COEFS, sk);
		write_reg(pvl_pkg::REG_LIGHT_POS, lp);
		write_reg(pvl_pkg::REG_LIGHT_COL, lc);
		write_reg(pvl_pkg::REG_SHININESS, {40'd0, sh});
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [pvl_pkg::CFG_W-1:0] rand48();
		return {16'($urandom_range(65535)), $urandom};
	endfunction

	task automatic add_vertex(input int px, input int py, input int pz,
			input int nx, input int ny, input int nz);
		vertex_t v;
		v.px = 16'(px);
		v.py = 16'(py);
		v.pz = 16'(pz);
		v.nx = 16'(nx);
		v.ny = 16'(ny);
		v.nz = 16'(nz);
		pending_vertices.push_back(v);
	endtask

	task automatic add_random(input int count);
		int sel, span;
		for (int k = 0; k < count; k++) begin
			sel = $urandom_range(9);
			if (sel < 2) begin
				add_vertex($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				span = (sel < 7) ? 12288 : 32767;
				add_vertex($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
					$urandom_range(2 * span) - span, $urandom_range(32768) - 16384,
					$urandom_range(32768) - 16384, $urandom_range(32768) - 16384);
			end
		end
	endtask

	// Runs the queued vertices through, then lets the pipeline drain.
	task automatic run_phase();
		wait (pending_vertices.size() == 0 && expected_colors.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_valid <= 0;
		end else begin
			if (vertex_valid && !vertex_stall) begin
				expected_colors.push_back(shade_vertex('{pos_x, pos_y, pos_z,
					norm_x, norm_y, norm_z}));
				vertices_sent++;
			end
			if (!vertex_valid || !vertex_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					vertex_valid <= 0;
				end else if (pending_vertices.size() > 0) begin
					vertex_t v;
					v = pending_vertices.pop_front();
					pos_x <= v.px;
					pos_y <= v.py;
					pos_z <= v.pz;
					norm_x <= v.nx;
					norm_y <= v.ny;
					norm_z <= v.nz;
					vertex_valid <= 1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(40);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
					end
				end else begin
					vertex_valid <= 0;
				end
			end
		end
	end

	// Receiver stall pattern and color word checking.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_stall <= 0;
		end else begin
			if (color_valid && !color_stall) begin
				color_t e;
				colors_seen++;
				if (expected_colors.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected color word %h %h %h %b", red, green, blue,
							degenerate);
				end else begin
					e = expected_colors.pop_front();
					if (red !== e.r || green !== e.g || blue !== e.b
							|| degenerate !== e.dg) begin
						mismatches++;
						if (mismatches <= 10)
							$display("color mismatch: expected %h %h %h %b, got %h %h %h %b",
								e.r, e.g, e.b, e.dg, red, green, blue, degenerate);
					end
				end
			end
			if (stall_span == 0) begin
				stall_mode = $urandom_range(3);
				stall_span = $urandom_range(200, 20);
			end
			stall_span--;
			case (stall_mode)
				0: color_stall <= 0;
				1: color_stall <= ($urandom_range(9) < 3);
				2: color_stall <= ($urandom_range(19) != 0);
				default: color_stall <= ~color_stall;
			endcase
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[phong_vertex_lighting] ERROR");
			$finish;
		end
	end

	initial begin
		amb_level = pvl_pkg::RST_AMB_LEVEL;
		amb_k = pvl_pkg::RST_AMB_COEFS;
		dif_k = pvl_pkg::RST_DIF_COEFS;
		spc_k = pvl_pkg::RST_SPC_COEFS;
		light_pos = pvl_pkg::RST_LIGHT_POS;
		light_col = pvl_pkg::RST_LIGHT_COL;
		shine = pvl_pkg::RST_SHININESS;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// Directed vertices under the reset lighting.
		add_vertex(0, 0, 0, 0, 0, 16384);
		add_vertex(-16384, 16384, -12288, 0, 16384, 0);
		add_vertex(0, 0, 0, 0, 0, 0);
		add_vertex(32767, 32767, 32767, 32767, 32767, 32767);
		add_vertex(-32768, -32768, -32768, -32768, -32768, -32768);
		add_vertex(4096, 0, -16384, 0, 0, 16384);
		add_vertex(4096, 0, -16384, 0, 0, -16384);
		add_vertex(0, 0, -8192, -9459, 9459, 0);
		add_vertex(0, 0, -8192, 9459, -9459, 0);
		add_vertex(-32768, 32767, -32768, 16384, 0, 0);
		add_vertex(32767, -32768, 32767, 0, -16384, 0);
		add_vertex(1, 0, 0, 0, 0, 1);
		add_vertex(0, 0, -1, 0, 0, -1);
		add_vertex(-16384, 16384, -12287, 32767, -32768, 32767);
		add_vertex(-8192, 8192, -16384, -8192, 8192, 8192);
		add_random(200);
		run_phase();

		write_all(16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
			48'h7FFF_7FFF_7FFF, 48'hFFFF_FFFF_FFFF, 8'd1);
		add_vertex(0, 0, 0, 16384, 16384, 16384);
		add_vertex(32767, 32767, 32767, 0, 0, 0);
		add_random(180);
		run_phase();

		write_all(16'd0, 48'd0, 48'h8000_8000_8000, 48'h8000_8000_8000,
			48'h8000_8000_8000, 48'h8000_8000_8000, 8'd255);
		add_vertex(-32768, -32768, -32768, 16384, 0, 0);
		add_random(180);
		run_phase();

		write_all(16'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 8'd2);
		add_vertex(0, 0, 0, 16384, 0, 0);
		add_random(120);
		run_phase();

		for (int ph = 0; ph < 4; ph++) begin
			write_all(16'($urandom), rand48(), rand48(), rand48(),
				{16'($urandom_range(65535)), 16'($urandom_range(65535)),
					16'($urandom_range(65535))},
				rand48(), 8'($urandom_range(255, 1)));
			add_random(140);
			run_phase();
		end

		$display("Lit %0d vertices and checked %0d color words over eight lighting setups,",
			vertices_sent, colors_seen);
		$display("including saturating, all-zero and degenerate-vector cases.");
		if (mismatches == 0) begin
			$display("[phong_vertex_lighting] OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[phong_vertex_lighting] ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pvl_pkg.sv
rtl/pvl_norm.sv
rtl/pvl_pow.sv
rtl/phong_vertex_lighting.sv
test/phong_vertex_lighting_tb.sv
